@@ hw/rtl/lfdb_pkg.sv @@
// Shared constants and controller/datapath link types for the lidar frame deframer.
package lfdb_pkg;

    // Frame layout
    localparam int FRAME_LEN_DEF    = 85;
    localparam int POINTS_PER_FRAME = 25;
    localparam int PT_IDX_W         = 5;
    localparam int ANG_FIRST        = 4;   // start angle lo, hi, end angle lo, hi
    localparam int ANG_BYTES        = 4;
    localparam int DIST_FIRST       = 11;  // low distance byte of the first point
    localparam int DIST_STRIDE      = 3;

    // Header bytes
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int BIN_W  = 9;
    localparam int DIST_W = 14;

    // Angle arithmetic, 1/64 degree units
    localparam logic [16:0] FULL_TURN  = 17'd23040;
    localparam logic [10:0] BINS       = 11'd360;
    localparam logic [15:0] THIRD_RECIP = 16'd43691;  // ceil(2^17 / 3)

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_byte;   // store accepted byte at the fill count
        logic clr_cnt;   // trigger byte: restart the hunt
        logic prep;      // latch start angle and wrapped end angle
        logic init;      // angle step and first accumulator value
        logic rd_hi;     // second read of a point, capture low byte
        logic calc;      // distance and bin quotient
        logic load;      // fill output register, advance to next point
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic hdr1;      // incoming byte is the first header
        logic hdr2;      // incoming byte is the second header
        logic full;      // frame store holds a whole frame
        logic last;      // current point is the last of the frame
        logic out_free;  // output register can take a point
    } sts_t;

endpackage

@@ hw/rtl/lfdb_rx_if.sv @@
// Byte input channel: valid/ready with one received byte.
interface lfdb_rx_if
    import lfdb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/lfdb_pt_if.sv @@
// Point output channel: valid/ready with one bin write.
interface lfdb_pt_if
    import lfdb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BIN_W-1:0]  bin_index;
    logic              bin_valid;
    logic [DIST_W-1:0] distance;
    logic              last_point;

    modport source (output valid, output bin_index, output bin_valid, output distance,
                    output last_point, input ready);
    modport sink   (input valid, input bin_index, input bin_valid, input distance,
                    input last_point, output ready);
endinterface

@@ hw/rtl/lfdb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lfdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 85
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lfdb_ctrl.sv @@
// Controller: header hunt, frame fill and per-point decode sequencing.
module lfdb_ctrl
    import lfdb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic rx_valid,
    output logic rx_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_FILL,
        ST_PREP,
        ST_INIT,
        ST_RD_LO,
        ST_RD_HI,
        ST_CALC,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rx_fire;

    assign rx_ready = (state_reg == ST_HUNT1) || (state_reg == ST_HUNT2)
                   || (state_reg == ST_FILL);
    assign rx_fire  = rx_valid && rx_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT1:
            begin
                if (rx_fire && sts.hdr1)
                begin
                    cmd.wr_byte = 1'b1;
                    state_next  = ST_HUNT2;
                end
            end
            ST_HUNT2:
            begin
                if (rx_fire && sts.hdr2)
                begin
                    cmd.wr_byte = 1'b1;
                    state_next  = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (rx_fire)
                begin
                    if (sts.full)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = ST_PREP;
                    end
                    else
                    begin
                        cmd.wr_byte = 1'b1;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.last ? ST_HUNT1 : ST_RD_LO;
                end
            end
            default:
            begin
                state_next = ST_HUNT1;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/lfdb_dp.sv @@
// Datapath: byte counter, frame store, angle accumulator, bin divide and output register.
module lfdb_dp
    import lfdb_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BIN_W-1:0]  bin_index,
    output logic              bin_valid,
    output logic [DIST_W-1:0] distance,
    output logic              last_point
);

    localparam int CNT_W  = $clog2(FRAME_LEN + 1);
    localparam int ADDR_W = $clog2(FRAME_LEN);

    // Control registers
    logic [CNT_W-1:0]    cnt_reg;
    logic [PT_IDX_W-1:0] pt_idx_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                out_valid_reg;

    // Payload registers
    logic [BYTE_W-1:0]   ang_reg [ANG_BYTES];
    logic [15:0]         s_reg;
    logic [16:0]         e_reg;
    logic signed [17:0]  d_reg;
    logic signed [22:0]  n_reg;
    logic [10:0]         q_reg;
    logic                neg_reg;
    logic [BYTE_W-1:0]   lo_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [BIN_W-1:0]    bin_reg;
    logic                bin_valid_reg;
    logic [DIST_W-1:0]   dist_out_reg;
    logic                last_reg;

    logic [BYTE_W-1:0]   rdata;
    logic [ADDR_W-1:0]   raddr;
    logic [15:0]         s_new;
    logic [15:0]         e_new;
    logic [20:0]         n_first;
    logic [28:0]         q_prod;
    logic [10:0]         q_wrap;
    logic                b_ok;
    logic                out_free;

    // Frame store
    assign raddr = cmd.rd_hi ? (addr_reg + ADDR_W'(1)) : addr_reg;

    lfdb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_byte),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Angle and bin arithmetic
    assign s_new   = {ang_reg[1], 8'h00} | {9'h000, ang_reg[0][7:1]};
    assign e_new   = {ang_reg[3], 8'h00} | {9'h000, ang_reg[2][7:1]};
    assign n_first = {1'b0, s_reg, 4'h0} + {2'b00, s_reg, 3'h0};
    assign q_prod  = n_reg[21:9] * THIRD_RECIP;
    assign q_wrap  = (q_reg >= BINS) ? (q_reg - BINS) : q_reg;
    assign b_ok    = !neg_reg && (q_wrap < BINS);
    assign out_free = !out_valid_reg || out_ready;

    // Status
    assign sts.hdr1     = (rx_byte == HDR_FIRST);
    assign sts.hdr2     = (rx_byte == HDR_SECOND);
    assign sts.full     = (cnt_reg == CNT_W'(FRAME_LEN));
    assign sts.last     = (pt_idx_reg == PT_IDX_W'(POINTS_PER_FRAME - 1));
    assign sts.out_free = out_free;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pt_idx_reg    <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.wr_byte)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.init)
            begin
                pt_idx_reg <= '0;
                addr_reg   <= ADDR_W'(DIST_FIRST);
            end
            else if (cmd.load)
            begin
                pt_idx_reg <= pt_idx_reg + PT_IDX_W'(1);
                addr_reg   <= addr_reg + ADDR_W'(DIST_STRIDE);
            end

            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload path
    always_ff @(posedge clk)
    begin
        // angle bytes are kept beside the store
        for (int k = 0; k < ANG_BYTES; k++)
        begin
            if (cmd.wr_byte && (cnt_reg == CNT_W'(ANG_FIRST + k)))
            begin
                ang_reg[k] <= rx_byte;
            end
        end

        // start angle, end angle unwrapped past a full turn
        if (cmd.prep)
        begin
            s_reg <= s_new;
            e_reg <= (s_new > e_new) ? ({1'b0, e_new} + FULL_TURN) : {1'b0, e_new};
        end

        // per-point step and 24*s starting value
        if (cmd.init)
        begin
            d_reg <= $signed({1'b0, e_reg}) - $signed({2'b00, s_reg});
            n_reg <= $signed({2'b00, n_first});
        end
        else if (cmd.calc)
        begin
            n_reg <= n_reg + 23'(d_reg);
        end

        if (cmd.rd_hi)
        begin
            lo_reg <= rdata;
        end

        // distance and floor(n / 1536) = floor((n >> 9) / 3)
        if (cmd.calc)
        begin
            dist_reg <= {rdata, lo_reg[7:2]};
            q_reg    <= q_prod[27:17];
            neg_reg  <= n_reg[22];
        end

        if (cmd.load)
        begin
            bin_reg       <= b_ok ? q_wrap[BIN_W-1:0] : '0;
            bin_valid_reg <= b_ok;
            dist_out_reg  <= dist_reg;
            last_reg      <= sts.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_index  = bin_reg;
    assign bin_valid  = bin_valid_reg;
    assign distance   = dist_out_reg;
    assign last_point = last_reg;

endmodule

@@ hw/rtl/lidar_frame_deframer_binner_core.sv @@
// Top level of the lidar frame deframer and angle binner.
//
//   channel | dir | transfer             | payload
//   --------+-----+----------------------+---------------------------------------------
//   rx      | in  | one serial byte      | rx_byte[7:0]
//   pt      | out | one point bin write  | bin_index[8:0] bin_valid distance[13:0]
//           |     |                      | last_point
//
// While hunting and filling, one byte is taken each cycle. The trigger byte that follows a
// full frame starts decoding: setup steps (prep, init), then per point two frame store
// reads, one divide step and one output load; rx ready stays low meanwhile. A stalled
// output holds the sequencer in its load step.
// Reset clears the byte count and output valid; the frame store is not cleared.
module lidar_frame_deframer_binner_core
    import lfdb_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lfdb_rx_if.sink    rx,
    lfdb_pt_if.source  pt
);

    cmd_t cmd;
    sts_t sts;

    lfdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfdb_dp #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .rx_byte    (rx.rx_byte),
        .out_valid  (pt.valid),
        .out_ready  (pt.ready),
        .bin_index  (pt.bin_index),
        .bin_valid  (pt.bin_valid),
        .distance   (pt.distance),
        .last_point (pt.last_point)
    );

    // No byte is taken while a frame is still being decoded
    a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && pt.ready && !pt.last_point |-> !rx.ready)
        else $error("byte accepted during frame decode");

    // Suppressed writes carry bin zero
    a_invalid_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && !pt.bin_valid |-> pt.bin_index == '0)
        else $error("invalid point with nonzero bin");

    // Valid bins lie within one turn
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && pt.bin_valid |-> pt.bin_index < BIN_W'(360))
        else $error("bin index out of range");

    // No two datapath commands, storage or decode, are issued together
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_byte, cmd.clr_cnt, cmd.prep, cmd.init, cmd.rd_hi, cmd.calc,
                  cmd.load}))
        else $error("overlapping datapath commands");

endmodule

@@ tb/lidar_frame_deframer_binner_core_tb.sv @@
// Self-checking testbench for the lidar frame deframer and angle binner core.
module lidar_frame_deframer_binner_core_tb;
    import lfdb_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int STREAM_BYTES   = 310;
    localparam int SPAN_STEPS     = 24;
    localparam int BIN_DIVISOR    = 1536;   // 64ths of a degree per bin, times 24 steps
    localparam int DRAIN_CYCLES   = 120;    // idle wait once every expected point has been seen

    // Angle pattern used for the header angles of a generated frame
    typedef enum int {
        ANG_ASCEND,    // start high byte at or below the end high byte
        ANG_WRAP,      // start above end by less than a full turn
        ANG_BEYOND,    // start above end by more than a full turn
        ANG_HIGH,      // large angles, bins at or beyond 720
        ANG_ANY
    } angle_kind_e;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_index;
        logic              bin_valid;
        logic [DIST_W-1:0] distance;
        logic              last_point;
    } bin_write_t;

    // Predicts bin writes from the accepted byte stream and checks the DUT output
    class bin_write_predictor;
        logic [BYTE_W-1:0] frame_bytes [FRAME_LEN_DEF];
        int                fill;
        bin_write_t        expected_writes [$];
        int                mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        task report(input string what, input int got, input int want);
            if (mismatches < 40)
                $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        // Expand a stored frame into its 25 point writes
        function void decode_frame();
            int         s_ang;
            int         e_ang;
            int         acc;
            int         bin;
            int         k;
            bin_write_t w;
            s_ang = (int'(frame_bytes[ANG_FIRST + 1]) << 8) + (int'(frame_bytes[ANG_FIRST]) >> 1);
            e_ang = (int'(frame_bytes[ANG_FIRST + 3]) << 8)
                  + (int'(frame_bytes[ANG_FIRST + 2]) >> 1);
            if (s_ang > e_ang)
                e_ang += int'(FULL_TURN);
            for (k = 0; k < POINTS_PER_FRAME; k++)
            begin
                acc = SPAN_STEPS * s_ang + k * (e_ang - s_ang);
                w   = '0;
                if (acc >= 0)
                begin
                    bin = acc / BIN_DIVISOR;
                    if (bin >= int'(BINS))
                        bin -= int'(BINS);
                    if (bin < int'(BINS))
                    begin
                        w.bin_valid = 1'b1;
                        w.bin_index = bin[BIN_W-1:0];
                    end
                end
                w.distance = DIST_W'((int'(frame_bytes[DIST_FIRST + 1 + DIST_STRIDE * k]) << 6)
                                   + (int'(frame_bytes[DIST_FIRST + DIST_STRIDE * k]) >> 2));
                w.last_point = (k == POINTS_PER_FRAME - 1);
                expected_writes.push_back(w);
            end
        endfunction

        // Accepted input byte: hunt, fill, or trigger decode
        function void note_byte(input logic [BYTE_W-1:0] value);
            if (fill == 0)
            begin
                if (value == HDR_FIRST)
                begin
                    frame_bytes[0] = value;
                    fill           = 1;
                end
            end
            else if (fill == 1)
            begin
                if (value == HDR_SECOND)
                begin
                    frame_bytes[1] = value;
                    fill           = 2;
                end
            end
            else if (fill < FRAME_LEN_DEF)
            begin
                frame_bytes[fill] = value;
                fill++;
            end
            else
            begin
                fill = 0;
                decode_frame();
            end
        endfunction

        // Accepted output point against the oldest expectation
        task check_point(input bin_write_t got);
            bin_write_t want;
            if (expected_writes.size() == 0)
            begin
                report("unexpected point write, bin_index", int'(got.bin_index), -1);
                return;
            end
            want = expected_writes.pop_front();
            if (got.bin_index !== want.bin_index)
                report("bin_index", int'(got.bin_index), int'(want.bin_index));
            if (got.bin_valid !== want.bin_valid)
                report("bin_valid", int'(got.bin_valid), int'(want.bin_valid));
            if (got.distance !== want.distance)
                report("distance", int'(got.distance), int'(want.distance));
            if (got.last_point !== want.last_point)
                report("last_point", int'(got.last_point), int'(want.last_point));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lfdb_rx_if rx_ch ();
    lfdb_pt_if pt_ch ();

    bin_write_predictor sb;
    int                 bytes_sent = 0;

    lidar_frame_deframer_binner_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .pt    (pt_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Send one byte, with an optional random gap before it
    task automatic send_byte(input logic [BYTE_W-1:0] value, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sb.note_byte(value);
        bytes_sent++;
    endtask

    // One well-formed frame plus its trigger byte
    task automatic send_frame(input angle_kind_e kind, input bit no_gaps);
        logic [BYTE_W-1:0] frame [FRAME_LEN_DEF + 1];
        int                s_hi;
        int                e_hi;
        int                k;
        for (k = 0; k <= FRAME_LEN_DEF; k++)
            frame[k] = BYTE_W'($urandom_range(0, 255));
        frame[0] = HDR_FIRST;
        frame[1] = HDR_SECOND;
        case (kind)
            ANG_ASCEND:
            begin
                s_hi = $urandom_range(0, 89);
                e_hi = $urandom_range(s_hi, 90);
            end
            ANG_WRAP:
            begin
                s_hi = $urandom_range(60, 89);
                e_hi = $urandom_range(0, 30);
            end
            ANG_BEYOND:
            begin
                s_hi = $urandom_range(200, 255);
                e_hi = $urandom_range(0, 50);
            end
            ANG_HIGH:
            begin
                s_hi = $urandom_range(180, 255);
                e_hi = $urandom_range(s_hi, 255);
            end
            default:
            begin
                s_hi = $urandom_range(0, 255);
                e_hi = $urandom_range(0, 255);
            end
        endcase
        frame[ANG_FIRST + 1] = BYTE_W'(s_hi);
        frame[ANG_FIRST + 3] = BYTE_W'(e_hi);
        // Push distance bytes toward their extremes now and then
        for (k = DIST_FIRST; k < FRAME_LEN_DEF; k++)
            case ($urandom_range(0, 3))
                0: frame[k] = 8'h00;
                1: frame[k] = 8'hFF;
                default: ;
            endcase
        for (k = 0; k <= FRAME_LEN_DEF; k++)
            send_byte(frame[k], no_gaps);
    endtask

    // Output sink with random stalls and stall-free stretches
    initial
    begin
        int gap;
        bit steady;
        steady = 1'b0;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                pt_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pt_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pt_ch.valid);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && pt_ch.valid && pt_ch.ready)
            sb.check_point('{bin_index: pt_ch.bin_index, bin_valid: pt_ch.bin_valid,
                             distance: pt_ch.distance, last_point: pt_ch.last_point});
    end

    // Stimulus and end of test
    initial
    begin
        int          frames;
        int          noise;
        bit          no_gaps;
        angle_kind_e kind;
        logic [BYTE_W-1:0] junk;
        sb = new();
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header hunt: stray bytes, lone second header, missing second header
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(HDR_SECOND, 1'b0);
        send_byte(HDR_FIRST, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(HDR_FIRST, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h54, 1'b0);

        // Frames with random content, the four fixed angle patterns first, noise in between
        frames = 0;
        while (bytes_sent < STREAM_BYTES)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            kind    = (frames < 4) ? angle_kind_e'(frames) : angle_kind_e'($urandom_range(0, 4));
            send_frame(kind, no_gaps);
            noise = $urandom_range(0, 4);
            repeat (noise)
            begin
                case ($urandom_range(0, 3))
                    0: junk = HDR_FIRST;
                    1: junk = HDR_SECOND;
                    default: junk = BYTE_W'($urandom_range(0, 255));
                endcase
                send_byte(junk, no_gaps);
            end
            // Hold the input once until the output has fully drained
            if (frames == 1)
            begin
                rx_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
            frames++;
        end

        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/lfdb_pkg.sv
hw/rtl/lfdb_rx_if.sv
hw/rtl/lfdb_pt_if.sv
hw/rtl/lfdb_ram.sv
hw/rtl/lfdb_ctrl.sv
hw/rtl/lfdb_dp.sv
hw/rtl/lidar_frame_deframer_binner_core.sv
tb/lidar_frame_deframer_binner_core_tb.sv
